// ----- sv/url_path_decode_normalize_defines.svh -----
// Assertion macros used by the checker file.
`ifndef URL_PATH_DECODE_NORMALIZE_DEFINES_SVH
`define URL_PATH_DECODE_NORMALIZE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define UDN_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define UDN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/udn_pkg.sv -----
package udn_pkg;

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_PERCENT   = 8'h25;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   localparam int UDN_QUEUE_DEPTH = 4;

   // Slots of one burst, emitted in this order.
   localparam int SLOT_SLASH = 0;
   localparam int SLOT_DOT1  = 1;
   localparam int SLOT_DOT2  = 2;
   localparam int SLOT_BYTE  = 3;
   localparam int SLOT_DONE  = 4;
   localparam int NUM_SLOTS  = 5;

   typedef enum logic [1:0] {
      PH_NORMAL,
      PH_HIGH,
      PH_LOW
   } phase_type;

   typedef enum logic [1:0] {
      SEG_EMPTY,
      SEG_DOT,
      SEG_DOTDOT,
      SEG_TEXT
   } seg_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_ESCAPE,
      ST_CHAR,
      ST_DOTDOT
   } status_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic [7:0]           data;
      status_type           status;
   } burst_type;

   // Bit 4 set means not a hex digit; bits 3:0 hold the value.
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b10000;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b0, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

// ----- sv/udn_if.sv -----
interface udn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       has_byte;
   logic       path_end;

   modport source(output valid, in_byte, has_byte, path_end, input ready);
   modport sink(input valid, in_byte, has_byte, path_end, output ready);
endinterface

interface udn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       done_res;
   logic [1:0] status;

   modport source(output valid, out_byte, out_valid, done_res, status, input ready);
   modport sink(input valid, out_byte, out_valid, done_res, status, output ready);
endinterface

// ----- sv/url_path_decode_normalize.sv -----
// Channel    Dir   Payload                                  Accepted when
// req_chan   in    in_byte[8] has_byte[1] path_end[1]       valid && ready
// rsp_chan   out   out_byte[8] out_valid[1] done_res[1]     valid && ready
//                  status[2]
//
// The front accepts an item every cycle while the queue has room. An item can
// release up to five results (separator, two held dots, the byte, the end
// result); the back emits one per cycle from the queue head while the output
// is not stalled. The first result passes through the queue and the output
// register. Synchronous reset clears all path state, the queue pointers and
// count, and the output valid flag.
module url_path_decode_normalize #(
   parameter int QueueDepth = udn_pkg::UDN_QUEUE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   udn_req_if.sink    req_chan,
   udn_rsp_if.source  rsp_chan
);
   import udn_pkg::*;

   burst_type front_burst;
   burst_type q_head;
   logic      front_push;
   logic      take;
   logic      q_full;
   logic      q_empty;
   logic      q_pop;

   // Accept whenever the queue can take a burst.
   assign req_chan.ready = !q_full;
   assign take           = req_chan.valid && req_chan.ready;

   // Front: decode escapes, track segments, build the burst for this item.
   udn_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .in_byte     (req_chan.in_byte),
      .has_byte    (req_chan.has_byte),
      .path_end    (req_chan.path_end),
      .burst       (front_burst),
      .burst_valid (front_push)
   );

   // Queue: hold bursts so input and output stall independently.
   udn_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_burst),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back: unpack each burst into result items, one per cycle while the output is not stalled.
   udn_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (q_head),
      .empty (q_empty),
      .pop   (q_pop),
      .rsp   (rsp_chan)
   );

endmodule

// ----- sv/udn_front.sv -----
module udn_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        in_byte,
   input  logic              has_byte,
   input  logic              path_end,
   output udn_pkg::burst_type burst,
   output logic              burst_valid
);
   import udn_pkg::*;

   phase_type  phase_ff, phase_in, phase_mid;
   logic [3:0] nib_ff, nib_in, nib_mid;
   seg_type    seg_ff, seg_in, seg_mid;
   logic       started_ff, started_in, started_mid;
   status_type err_ff, err_in, err_mid;

   logic [4:0] hv;
   logic       esc_err;
   logic       dec_valid;
   logic [7:0] dec_byte;
   logic [NUM_SLOTS-1:0] mask;
   status_type final_status;

   // Escape decoding.
   always_comb begin
      hv        = hex_val(in_byte);
      phase_mid = phase_ff;
      nib_mid   = nib_ff;
      esc_err   = 1'b0;
      dec_valid = 1'b0;
      dec_byte  = in_byte;
      if (has_byte && err_ff == ST_OK) begin
         unique case (phase_ff)
            PH_HIGH: begin
               if (hv[4]) begin
                  esc_err = 1'b1;
               end else begin
                  nib_mid   = hv[3:0];
                  phase_mid = PH_LOW;
               end
            end
            PH_LOW: begin
               if (hv[4]) begin
                  esc_err = 1'b1;
               end else begin
                  phase_mid = PH_NORMAL;
                  dec_valid = 1'b1;
                  dec_byte  = {nib_ff, hv[3:0]};
               end
            end
            default: begin
               phase_mid = PH_NORMAL;
               if (in_byte == CH_PERCENT) begin
                  phase_mid = PH_HIGH;
               end else begin
                  dec_valid = 1'b1;
               end
            end
         endcase
      end
   end

   // Segment tracking and release of held bytes.
   always_comb begin
      seg_mid     = seg_ff;
      started_mid = started_ff;
      err_mid     = esc_err ? ST_ESCAPE : err_ff;
      mask        = '0;
      if (dec_valid) begin
         priority if (dec_byte == CH_NUL || dec_byte == CH_BACKSLASH) begin
            err_mid = ST_CHAR;
         end else if (dec_byte == CH_SLASH) begin
            if (seg_ff == SEG_DOTDOT) begin
               err_mid = ST_DOTDOT;
            end else begin
               seg_mid = SEG_EMPTY;
            end
         end else if (seg_ff == SEG_TEXT) begin
            mask[SLOT_BYTE] = 1'b1;
         end else if (dec_byte == CH_DOT && seg_ff != SEG_DOTDOT) begin
            seg_mid = (seg_ff == SEG_EMPTY) ? SEG_DOT : SEG_DOTDOT;
         end else begin
            mask[SLOT_SLASH] = started_ff;
            mask[SLOT_DOT1]  = (seg_ff != SEG_EMPTY);
            mask[SLOT_DOT2]  = (seg_ff == SEG_DOTDOT);
            mask[SLOT_BYTE]  = 1'b1;
            seg_mid          = SEG_TEXT;
            started_mid      = 1'b1;
         end
      end
      mask[SLOT_DONE] = path_end;
   end

   // End-of-path status.
   always_comb begin
      final_status = err_mid;
      if (err_mid == ST_OK) begin
         if (phase_mid != PH_NORMAL) begin
            final_status = ST_ESCAPE;
         end else if (seg_mid == SEG_DOTDOT) begin
            final_status = ST_DOTDOT;
         end
      end
   end

   assign burst.mask   = mask;
   assign burst.data   = dec_byte;
   assign burst.status = final_status;
   assign burst_valid  = take && (|mask);

   always_comb begin
      phase_in   = phase_ff;
      nib_in     = nib_ff;
      seg_in     = seg_ff;
      started_in = started_ff;
      err_in     = err_ff;
      if (take) begin
         if (path_end) begin
            phase_in   = PH_NORMAL;
            nib_in     = '0;
            seg_in     = SEG_EMPTY;
            started_in = 1'b0;
            err_in     = ST_OK;
         end else begin
            phase_in   = phase_mid;
            nib_in     = nib_mid;
            seg_in     = seg_mid;
            started_in = started_mid;
            err_in     = err_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_NORMAL;
         nib_ff     <= '0;
         seg_ff     <= SEG_EMPTY;
         started_ff <= 1'b0;
         err_ff     <= ST_OK;
      end else begin
         phase_ff   <= phase_in;
         nib_ff     <= nib_in;
         seg_ff     <= seg_in;
         started_ff <= started_in;
         err_ff     <= err_in;
      end
   end

endmodule

// ----- sv/udn_queue.sv -----
module udn_queue #(
   parameter int Depth = udn_pkg::UDN_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  udn_pkg::burst_type push_data,
   input  logic              pop,
   output udn_pkg::burst_type head,
   output logic              full,
   output logic              empty
);
   import udn_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   burst_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full  = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/udn_back.sv -----
module udn_back (
   input  logic              clock,
   input  logic              reset,
   input  udn_pkg::burst_type head,
   input  logic              empty,
   output logic              pop,
   udn_rsp_if.source         rsp
);
   import udn_pkg::*;

   logic [NUM_SLOTS-1:0] used_ff, used_in;
   logic [NUM_SLOTS-1:0] pending, sel, rest;
   logic                 load, emit;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       outv_ff, outv_in;
   logic       done_ff, done_in;
   status_type status_ff, status_in;

   assign pending = empty ? '0 : (head.mask & ~used_ff);
   assign sel     = pending & (~pending + 1'b1);
   assign rest    = pending & ~sel;
   assign load    = !valid_ff || rsp.ready;
   assign emit    = load && (|pending);
   assign pop     = emit && (rest == '0);

   always_comb begin
      used_in = used_ff;
      if (emit) begin
         used_in = pop ? '0 : (used_ff | sel);
      end
   end

   always_comb begin
      valid_in  = load ? (|pending) : valid_ff;
      byte_in   = byte_ff;
      outv_in   = outv_ff;
      done_in   = done_ff;
      status_in = status_ff;
      if (emit) begin
         byte_in   = head.data;
         outv_in   = 1'b1;
         done_in   = 1'b0;
         status_in = ST_OK;
         priority if (sel[SLOT_SLASH]) begin
            byte_in = CH_SLASH;
         end else if (sel[SLOT_DOT1] || sel[SLOT_DOT2]) begin
            byte_in = CH_DOT;
         end else if (sel[SLOT_DONE]) begin
            byte_in   = '0;
            outv_in   = 1'b0;
            done_in   = 1'b1;
            status_in = head.status;
         end else begin
            byte_in = head.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      outv_ff   <= outv_in;
      done_ff   <= done_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         used_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.out_byte  = byte_ff;
   assign rsp.out_valid = outv_ff;
   assign rsp.done_res  = done_ff;
   assign rsp.status    = status_ff;

endmodule

// ----- sv/udn_checker.sv -----
`include "url_path_decode_normalize_defines.svh"

module udn_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_valid,
   input logic       rsp_done_res,
   input logic [1:0] rsp_status
);
   import udn_pkg::*;

   `UDN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_out_byte, rsp_out_valid, rsp_done_res, rsp_status}), "stalled result changed")
   `UDN_ASSERT_IMPLY(a_one_kind, clock, reset, rsp_valid, rsp_out_valid != rsp_done_res, "result must be a byte or the end")
   `UDN_ASSERT_IMPLY(a_byte_status, clock, reset, rsp_valid && rsp_out_valid, rsp_status == ST_OK, "byte result with status")
   `UDN_ASSERT_IMPLY(a_done_byte, clock, reset, rsp_valid && rsp_done_res, rsp_out_byte == CH_NUL, "end result with data")

endmodule

bind url_path_decode_normalize udn_checker u_udn_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_byte  (rsp_chan.out_byte),
   .rsp_out_valid (rsp_chan.out_valid),
   .rsp_done_res  (rsp_chan.done_res),
   .rsp_status    (rsp_chan.status)
);
